>>> hw/rtl/rle8sd_pkg.sv
// ----------------------------------------------------------------------------
// rle8sd_pkg
// Shared types and constants of the RLE8 span decoder.
// ----------------------------------------------------------------------------
package rle8sd_pkg;

    localparam int ColW     = 13;
    localparam int CountW   = 8;
    localparam int CfgAddrW = 8;

    localparam logic [ColW-1:0] ColMax        = 13'h1FFF;
    localparam logic [ColW-1:0] WidthReset    = 13'd320;
    localparam logic [ColW-1:0] HeightReset   = 13'd240;
    localparam logic [ColW-1:0] WidthMin      = 13'd8;
    localparam logic [ColW-1:0] HeightMin     = 13'd1;

    localparam logic [CfgAddrW-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CfgAddrW-1:0] REG_IMAGE_HEIGHT = 8'd1;

    localparam logic [7:0] ESC_EOL   = 8'h00;
    localparam logic [7:0] ESC_EOB   = 8'h01;
    localparam logic [7:0] ESC_DELTA = 8'h02;

    localparam logic KIND_SPAN      = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [11:0] span_column;
        logic [11:0] span_row;
        logic [7:0]  span_length;
        logic [7:0]  color_index;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        logic              in_row;
        logic              wrap;
        logic [CountW-1:0] take;
        logic [ColW-1:0]   col_next;
    } span_calc_t;

endpackage

>>> hw/rtl/rle8sd_span_unit.sv
// ----------------------------------------------------------------------------
// rle8sd_span_unit
// Cuts the pending run at the row end: span length, wrap and next column.
// ----------------------------------------------------------------------------
module rle8sd_span_unit (
    input  logic [rle8sd_pkg::ColW-1:0]   column,
    input  logic [rle8sd_pkg::ColW-1:0]   width,
    input  logic [rle8sd_pkg::CountW-1:0] remaining,
    output rle8sd_pkg::span_calc_t        calc
);

    logic [rle8sd_pkg::ColW-1:0] room;
    logic [rle8sd_pkg::ColW-1:0] rem_ext;

    assign room    = width - column;
    assign rem_ext = {5'd0, remaining};

    always_comb begin
        calc.in_row = (column < width);
        if (!calc.in_row) begin
            // pixel past the row end: dropped, still wraps
            calc.take     = 8'd1;
            calc.wrap     = 1'b1;
            calc.col_next = '0;
        end else if (rem_ext >= room) begin
            calc.take     = room[7:0];
            calc.wrap     = 1'b1;
            calc.col_next = '0;
        end else begin
            calc.take     = remaining;
            calc.wrap     = 1'b0;
            calc.col_next = column + rem_ext;
        end
    end

endmodule

>>> hw/rtl/rle8sd_out_buf.sv
// ----------------------------------------------------------------------------
// rle8sd_out_buf
// Single-entry output register for result items.
// ----------------------------------------------------------------------------
module rle8sd_out_buf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  rle8sd_pkg::out_item_t item_in,
    output logic                  can_load,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rle8sd_pkg::out_item_t m_data
);

    logic                  valid_reg;
    logic                  valid_next;
    rle8sd_pkg::out_item_t data_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= item_in;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

>>> hw/rtl/bmp_rle8_span_decoder_top.sv
// ----------------------------------------------------------------------------
// bmp_rle8_span_decoder_top: RLE8 byte stream to pixel spans.
// A byte is parsed in the idle state; a painting byte then goes through the
// span unit in the paint state, one span or dropped pixel at a time, and a
// frame end leaves from the frame-end state. Throughput: one byte per cycle
// when nothing is painted or ended; paint, frame end and stalls hold the input.
// Sync active-low reset: width 320, height 240, next byte starts a frame.
// ----------------------------------------------------------------------------
module bmp_rle8_span_decoder_top #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rle8sd_pkg::in_item_t                s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rle8sd_pkg::out_item_t               m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rle8sd_pkg::CfgAddrW-1:0]     cfg_addr,
    input  logic [rle8sd_pkg::ColW-1:0]         cfg_wdata
);

    localparam logic [13:0] MaxDim = 14'(MAX_DIMENSION);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PAINT = 3'b010,
        ST_FEND  = 3'b100
    } seq_state_t;

    typedef enum logic [6:0] {
        PH_COUNT = 7'b0000001,
        PH_VALUE = 7'b0000010,
        PH_DX    = 7'b0000100,
        PH_DY    = 7'b0001000,
        PH_LIT   = 7'b0010000,
        PH_PAD   = 7'b0100000,
        PH_DONE  = 7'b1000000
    } phase_t;

    seq_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;

    logic [rle8sd_pkg::ColW-1:0]   width_reg, height_reg;
    logic [rle8sd_pkg::ColW-1:0]   col_reg, col_next;
    logic [rle8sd_pkg::ColW-1:0]   row_reg, row_next;
    logic [rle8sd_pkg::CountW-1:0] held_reg, held_next;
    logic [rle8sd_pkg::CountW-1:0] lit_rem_reg, lit_rem_next;
    logic [rle8sd_pkg::CountW-1:0] rem_reg, rem_next;
    logic [7:0]                    color_reg, color_next;
    logic                          lit_odd_reg, lit_odd_next;
    logic                          wrapped_reg, wrapped_next;
    logic                          fstart_reg, fstart_next;
    logic                          fin_reg, fin_next;

    logic [rle8sd_pkg::ColW-1:0] eff_w, eff_h;
    phase_t                      ph_c, ph_n;
    logic [rle8sd_pkg::ColW-1:0] col_c, row_c;
    logic [rle8sd_pkg::CountW-1:0] lit_rem_c, lit_rem_dec, rem_dec;
    logic                        lit_odd_c, wr_c;
    logic [13:0]                 col_sum;
    logic                        end_f, paint_f;
    logic [rle8sd_pkg::CountW-1:0] paint_n;
    logic                        in_acc;

    rle8sd_pkg::span_calc_t calc;
    rle8sd_pkg::out_item_t  out_item;
    logic                   out_load;
    logic                   out_can_load;

    // effective dimensions
    always_comb begin
        eff_w = width_reg;
        if (width_reg < rle8sd_pkg::WidthMin) begin
            eff_w = rle8sd_pkg::WidthMin;
        end else if ({1'b0, width_reg} > MaxDim) begin
            eff_w = MaxDim[12:0];
        end
        eff_h = height_reg;
        if (height_reg < rle8sd_pkg::HeightMin) begin
            eff_h = rle8sd_pkg::HeightMin;
        end else if ({1'b0, height_reg} > MaxDim) begin
            eff_h = MaxDim[12:0];
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // frame start reloads position state
    assign ph_c      = fstart_reg ? PH_COUNT : phase_reg;
    assign col_c     = fstart_reg ? '0 : col_reg;
    assign row_c     = fstart_reg ? (eff_h - 13'd1) : row_reg;
    assign wr_c      = fstart_reg ? 1'b0 : wrapped_reg;
    assign lit_rem_c = fstart_reg ? '0 : lit_rem_reg;
    assign lit_odd_c = fstart_reg ? 1'b0 : lit_odd_reg;

    assign col_sum     = {1'b0, col_c} + {6'd0, s_data.data_byte};
    assign lit_rem_dec = (lit_rem_c != 8'd0) ? (lit_rem_c - 8'd1) : 8'd0;

    rle8sd_span_unit u_span (
        .column    (col_reg),
        .width     (eff_w),
        .remaining (rem_reg),
        .calc      (calc)
    );

    assign rem_dec = rem_reg - calc.take;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        held_next    = held_reg;
        lit_rem_next = lit_rem_reg;
        lit_odd_next = lit_odd_reg;
        wrapped_next = wrapped_reg;
        fstart_next  = fstart_reg;
        fin_next     = fin_reg;
        rem_next     = rem_reg;
        color_next   = color_reg;
        ph_n         = ph_c;
        end_f        = 1'b0;
        paint_f      = 1'b0;
        paint_n      = held_reg;
        out_load     = 1'b0;
        out_item     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    col_next     = col_c;
                    row_next     = row_c;
                    wrapped_next = wr_c;
                    lit_rem_next = lit_rem_c;
                    lit_odd_next = lit_odd_c;
                    unique case (ph_c)
                        PH_COUNT: begin
                            held_next = s_data.data_byte;
                            ph_n      = PH_VALUE;
                        end
                        PH_VALUE: begin
                            if (held_reg != 8'd0) begin
                                ph_n    = PH_COUNT;
                                paint_f = 1'b1;
                                paint_n = held_reg;
                            end else if (s_data.data_byte == rle8sd_pkg::ESC_EOL) begin
                                ph_n = PH_COUNT;
                                if (!wr_c) begin
                                    col_next = '0;
                                    if (row_c == '0) begin
                                        end_f = 1'b1;
                                    end else begin
                                        row_next = row_c - 13'd1;
                                    end
                                end
                                wrapped_next = 1'b0;
                            end else if (s_data.data_byte == rle8sd_pkg::ESC_EOB) begin
                                end_f = 1'b1;
                            end else if (s_data.data_byte == rle8sd_pkg::ESC_DELTA) begin
                                ph_n = PH_DX;
                            end else begin
                                lit_rem_next = s_data.data_byte;
                                lit_odd_next = s_data.data_byte[0];
                                ph_n         = PH_LIT;
                            end
                        end
                        PH_DX: begin
                            col_next = col_sum[13] ? rle8sd_pkg::ColMax : col_sum[12:0];
                            ph_n     = PH_DY;
                        end
                        PH_DY: begin
                            ph_n = PH_COUNT;
                            if ({5'd0, s_data.data_byte} > row_c) begin
                                end_f = 1'b1;
                            end else begin
                                row_next = row_c - {5'd0, s_data.data_byte};
                            end
                        end
                        PH_LIT: begin
                            lit_rem_next = lit_rem_dec;
                            if (lit_rem_dec == 8'd0) begin
                                ph_n = lit_odd_c ? PH_PAD : PH_COUNT;
                            end else begin
                                ph_n = PH_LIT;
                            end
                            paint_f = 1'b1;
                            paint_n = 8'd1;
                        end
                        PH_PAD: begin
                            ph_n = PH_COUNT;
                        end
                        PH_DONE: begin
                            ph_n = PH_DONE;
                        end
                        default: begin
                            ph_n = PH_COUNT;
                        end
                    endcase
                    phase_next  = end_f ? PH_DONE : ph_n;
                    fstart_next = s_data.final_byte;
                    fin_next    = s_data.final_byte;
                    if (paint_f) begin
                        state_next = ST_PAINT;
                        rem_next   = paint_n;
                        color_next = s_data.data_byte;
                    end else if (end_f || (s_data.final_byte && ph_n != PH_DONE)) begin
                        state_next = ST_FEND;
                    end
                end
            end
            ST_PAINT: begin
                if (!calc.in_row || out_can_load) begin
                    out_load             = calc.in_row;
                    out_item.result_kind = rle8sd_pkg::KIND_SPAN;
                    out_item.span_column = col_reg[11:0];
                    out_item.span_row    = row_reg[11:0];
                    out_item.span_length = calc.take;
                    out_item.color_index = color_reg;
                    out_item.last_of_run = !(calc.wrap && row_reg == '0)
                                           && rem_dec == 8'd0 && !fin_reg;
                    rem_next     = rem_dec;
                    col_next     = calc.col_next;
                    wrapped_next = calc.wrap;
                    if (calc.wrap && row_reg == '0) begin
                        phase_next = PH_DONE;
                        state_next = ST_FEND;
                    end else begin
                        if (calc.wrap) begin
                            row_next = row_reg - 13'd1;
                        end
                        if (rem_dec != 8'd0) begin
                            state_next = ST_PAINT;
                        end else if (fin_reg) begin
                            state_next = ST_FEND;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_FEND: begin
                if (out_can_load) begin
                    out_load             = 1'b1;
                    out_item.result_kind = rle8sd_pkg::KIND_FRAME_END;
                    out_item.last_of_run = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_COUNT;
            width_reg   <= rle8sd_pkg::WidthReset;
            height_reg  <= rle8sd_pkg::HeightReset;
            col_reg     <= '0;
            row_reg     <= rle8sd_pkg::HeightReset - 13'd1;
            held_reg    <= '0;
            lit_rem_reg <= '0;
            lit_odd_reg <= 1'b0;
            wrapped_reg <= 1'b0;
            fstart_reg  <= 1'b1;
            fin_reg     <= 1'b0;
            rem_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            held_reg    <= held_next;
            lit_rem_reg <= lit_rem_next;
            lit_odd_reg <= lit_odd_next;
            wrapped_reg <= wrapped_next;
            fstart_reg  <= fstart_next;
            fin_reg     <= fin_next;
            rem_reg     <= rem_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_addr == rle8sd_pkg::REG_IMAGE_WIDTH) begin
                    width_reg <= cfg_wdata;
                end else if (cfg_addr == rle8sd_pkg::REG_IMAGE_HEIGHT) begin
                    height_reg <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        color_reg <= color_next;
    end

    rle8sd_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .item_in  (out_item),
        .can_load (out_can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef SYNTH
    a_paint_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PAINT |-> rem_reg != 8'd0)
        else $error("paint state with empty run");

    a_fend_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind == rle8sd_pkg::KIND_FRAME_END
        |-> m_data.last_of_run)
        else $error("frame end item not marked last");

    a_fend_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && out_item.result_kind == rle8sd_pkg::KIND_FRAME_END
        |=> state_reg == ST_IDLE)
        else $error("sequencer busy after frame end");
`endif

endmodule

>>> sim/tb_bmp_rle8_span_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_bmp_rle8_span_decoder_top
// Drives RLE8 compressed frames into the span decoder with random gaps on both
// channels and checks every span and frame end against a behavioral decoder
// kept in the bench. Covers escapes, row wrap, suppressed pixels, early frame
// end, truncated frames and several image sizes including clamped ones.
// ----------------------------------------------------------------------------
module tb_bmp_rle8_span_decoder_top;

    localparam int MaxDim       = 4096;
    localparam int SettleCycles = 300;

    localparam logic [rle8sd_pkg::CfgAddrW-1:0] REG_UNUSED_LO = 8'd2;
    localparam logic [rle8sd_pkg::CfgAddrW-1:0] REG_UNUSED_HI = 8'hFF;

    typedef enum logic [2:0] {
        P_COUNT, P_VALUE, P_DX, P_DY, P_LITERAL, P_PAD, P_DONE
    } parse_phase_t;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              s_valid   = 1'b0;
    logic                              s_ready;
    rle8sd_pkg::in_item_t              s_data    = '0;
    logic                              m_valid;
    logic                              m_ready   = 1'b0;
    rle8sd_pkg::out_item_t             m_data;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [rle8sd_pkg::CfgAddrW-1:0]   cfg_addr  = '0;
    logic [rle8sd_pkg::ColW-1:0]       cfg_wdata = '0;

    int send_idle_pct = 36;
    int recv_idle_pct = 36;
    int error_count   = 0;

    // decoder state mirrored in the bench
    logic [rle8sd_pkg::ColW-1:0] cfg_width  = rle8sd_pkg::WidthReset;
    logic [rle8sd_pkg::ColW-1:0] cfg_height = rle8sd_pkg::HeightReset;
    parse_phase_t    phase      = P_COUNT;
    logic [7:0]      held       = '0;
    logic [7:0]      lit_left   = '0;
    logic            lit_odd    = 1'b0;
    int unsigned     col_pos    = 0;
    int unsigned     row_pos    = 239;
    logic            wrap_seen  = 1'b0;
    logic            new_frame  = 1'b1;

    logic                  run_open;
    int unsigned           run_col, run_row, run_len, run_color;
    rle8sd_pkg::out_item_t step_out[$];
    rle8sd_pkg::out_item_t spans_due[$];

    bmp_rle8_span_decoder_top #(
        .MAX_DIMENSION(MaxDim)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Span prediction
    // ------------------------------------------------------------------------
    function automatic int unsigned width_used();
        int unsigned w;
        w = 32'(cfg_width);
        if (w < 8) w = 8;
        if (w > MaxDim) w = MaxDim;
        return w;
    endfunction

    function automatic int unsigned height_used();
        int unsigned h;
        h = 32'(cfg_height);
        if (h < 1) h = 1;
        if (h > MaxDim) h = MaxDim;
        return h;
    endfunction

    function automatic void push_result(logic kind, int unsigned c, int unsigned r,
                                        int unsigned len, int unsigned color);
        rle8sd_pkg::out_item_t o;
        o.result_kind = kind;
        o.span_column = c[11:0];
        o.span_row    = r[11:0];
        o.span_length = len[7:0];
        o.color_index = color[7:0];
        o.last_of_run = 1'b0;
        step_out.push_back(o);
    endfunction

    function automatic void close_run();
        if (run_open) begin
            push_result(rle8sd_pkg::KIND_SPAN, run_col, run_row, run_len, run_color);
            run_open = 1'b0;
        end
    endfunction

    function automatic void finish_frame();
        close_run();
        push_result(rle8sd_pkg::KIND_FRAME_END, 0, 0, 0, 0);
        phase = P_DONE;
    endfunction

    function automatic void paint_pixels(int unsigned count, logic [7:0] color);
        int unsigned w;
        w = width_used();
        for (int unsigned i = 0; i < count; i++) begin
            if (col_pos < w) begin
                if (run_open) begin
                    run_len++;
                end else begin
                    run_open  = 1'b1;
                    run_col   = col_pos;
                    run_row   = row_pos;
                    run_len   = 1;
                    run_color = 32'(color);
                end
            end
            col_pos++;
            if (col_pos >= w) begin
                close_run();
                col_pos   = 0;
                wrap_seen = 1'b1;
                if (row_pos == 0) begin
                    finish_frame();
                    return;
                end
                row_pos--;
            end else begin
                wrap_seen = 1'b0;
            end
        end
        close_run();
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic fin);
        step_out.delete();
        run_open = 1'b0;
        if (new_frame) begin
            new_frame = 1'b0;
            phase     = P_COUNT;
            col_pos   = 0;
            row_pos   = height_used() - 1;
            wrap_seen = 1'b0;
            lit_left  = '0;
            lit_odd   = 1'b0;
        end
        case (phase)
            P_COUNT: begin
                held  = b;
                phase = P_VALUE;
            end
            P_VALUE: begin
                if (held != 0) begin
                    phase = P_COUNT;
                    paint_pixels(32'(held), b);
                end else if (b == rle8sd_pkg::ESC_EOL) begin
                    phase = P_COUNT;
                    if (!wrap_seen) begin
                        col_pos = 0;
                        if (row_pos == 0) finish_frame();
                        else row_pos--;
                    end
                    wrap_seen = 1'b0;
                end else if (b == rle8sd_pkg::ESC_EOB) begin
                    finish_frame();
                end else if (b == rle8sd_pkg::ESC_DELTA) begin
                    phase = P_DX;
                end else begin
                    lit_left = b;
                    lit_odd  = b[0];
                    phase    = P_LITERAL;
                end
            end
            P_DX: begin
                col_pos += 32'(b);
                if (col_pos > 32'(rle8sd_pkg::ColMax)) col_pos = 32'(rle8sd_pkg::ColMax);
                phase = P_DY;
            end
            P_DY: begin
                phase = P_COUNT;
                if (32'(b) > row_pos) finish_frame();
                else row_pos -= 32'(b);
            end
            P_LITERAL: begin
                if (lit_left > 0) lit_left--;
                if (lit_left != 0) phase = P_LITERAL;
                else if (lit_odd) phase = P_PAD;
                else phase = P_COUNT;
                paint_pixels(1, b);
            end
            P_PAD: begin
                phase = P_COUNT;
            end
            default: ;
        endcase
        if (fin) begin
            if (phase != P_DONE) finish_frame();
            new_frame = 1'b1;
            phase     = P_COUNT;
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
        foreach (step_out[i]) spans_due.push_back(step_out[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_error(input string msg);
        if (error_count < 200) $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [11:0] got,
                                 input logic [11:0] want);
        if (got !== want) begin
            report_error($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    always @(posedge aclk) begin : monitor
        rle8sd_pkg::out_item_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_addr == rle8sd_pkg::REG_IMAGE_WIDTH) cfg_width = cfg_wdata;
                else if (cfg_addr == rle8sd_pkg::REG_IMAGE_HEIGHT) cfg_height = cfg_wdata;
            end
            if (s_valid && s_ready) decode_byte(s_data.data_byte, s_data.final_byte);
            if (m_valid && m_ready) begin
                if (spans_due.size() == 0) begin
                    report_error($sformatf("result with nothing due: kind %0d col %0d row %0d",
                                           m_data.result_kind, m_data.span_column,
                                           m_data.span_row));
                end else begin
                    want = spans_due.pop_front();
                    compare_field("result_kind", 12'(m_data.result_kind),
                                  12'(want.result_kind));
                    compare_field("span_column", m_data.span_column, want.span_column);
                    compare_field("span_row",    m_data.span_row,    want.span_row);
                    compare_field("span_length", 12'(m_data.span_length),
                                  12'(want.span_length));
                    compare_field("color_index", 12'(m_data.color_index),
                                  12'(want.color_index));
                    compare_field("last_of_run", 12'(m_data.last_of_run),
                                  12'(want.last_of_run));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, final_byte: fin};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (spans_due.size() != 0);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [rle8sd_pkg::CfgAddrW-1:0] idx,
                             input logic [rle8sd_pkg::ColW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [rle8sd_pkg::ColW-1:0] w,
                             input logic [rle8sd_pkg::ColW-1:0] h,
                             input bit stray);
        drain();
        if (stray) begin
            write_reg(REG_UNUSED_HI, '1);
            write_reg(REG_UNUSED_LO, 13'd9);
        end
        write_reg(rle8sd_pkg::REG_IMAGE_WIDTH, w);
        write_reg(rle8sd_pkg::REG_IMAGE_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_bytes(input logic [7:0] bytes[$]);
        foreach (bytes[i]) send_byte(bytes[i], 1'b0);
    endtask

    // One frame of random commands; a broken frame is cut off at a random byte.
    task automatic send_frame(input bit broken, inout int sent);
        logic [7:0] bytes[$];
        int         n_cmds, pick, n;
        n_cmds = $urandom_range(6, 2);
        for (int c = 0; c < n_cmds; c++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(255, 1) : $urandom_range(12, 1);
                bytes.push_back(n[7:0]);
                bytes.push_back(8'($urandom_range(255)));
            end else if (pick < 57) begin
                bytes.push_back(8'h00);
                bytes.push_back(rle8sd_pkg::ESC_EOL);
            end else if (pick < 69) begin
                bytes.push_back(8'h00);
                bytes.push_back(rle8sd_pkg::ESC_DELTA);
                bytes.push_back(8'(($urandom_range(7) == 0) ? $urandom_range(255)
                                                              : $urandom_range(6)));
                bytes.push_back(8'(($urandom_range(9) == 0) ? $urandom_range(255)
                                                              : $urandom_range(1)));
            end else if (pick < 89) begin
                n = ($urandom_range(19) == 0) ? $urandom_range(64, 3) : $urandom_range(9, 3);
                bytes.push_back(8'h00);
                bytes.push_back(n[7:0]);
                repeat (n) bytes.push_back(8'($urandom_range(255)));
                if (n[0]) bytes.push_back(8'($urandom_range(255)));
            end else if (pick < 93) begin
                bytes.push_back(8'h00);
                bytes.push_back(rle8sd_pkg::ESC_EOB);
            end else begin
                bytes.push_back(8'($urandom_range(255)));
            end
        end
        if (broken) begin
            n = $urandom_range(bytes.size(), 1);
            while (bytes.size() > n) void'(bytes.pop_back());
        end
        foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
        sent += bytes.size();
    endtask

    task automatic random_frames(input int items);
        int sent;
        sent = 0;
        while (sent < items) send_frame($urandom_range(4) == 0, sent);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_escapes();
        configure(13'd8, 13'd3, 1'b0);
        // run, run that wraps, end of line right after the wrap
        send_bytes('{8'h05, 8'hAA, 8'h03, 8'h55, 8'h00, rle8sd_pkg::ESC_EOL});
        // delta then odd literal run with its pad byte
        send_bytes('{8'h00, rle8sd_pkg::ESC_DELTA, 8'h03, 8'h00});
        send_bytes('{8'h00, 8'h03, 8'h11, 8'h22, 8'h33, 8'h00});
        // delta far past the row end, then a full run: dropped pixel, wrap, row below zero
        send_bytes('{8'h00, rle8sd_pkg::ESC_DELTA, 8'hFF, 8'h00, 8'hFF, 8'h7F});
        send_byte(8'h12, 1'b1);
        // end of bitmap, then an ignored byte carrying the frame marker
        send_bytes('{8'h00, rle8sd_pkg::ESC_EOB});
        send_byte(8'hC3, 1'b1);
    endtask

    task automatic test_min_size();
        configure(13'd8, 13'd1, 1'b0);
        random_frames(15);
    endtask

    task automatic test_max_size();
        configure(13'd4096, 13'd4096, 1'b0);
        random_frames(15);
    endtask

    task automatic test_clamped_regs();
        configure(13'h1FFF, 13'd0, 1'b1);
        random_frames(15);
    endtask

    task automatic test_burst_odd_size();
        configure(13'd37, 13'd5, 1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_frames(25);
        drain();
        send_idle_pct = 36;
        recv_idle_pct = 36;
    endtask

    task automatic test_reset_size();
        configure(rle8sd_pkg::WidthReset, rle8sd_pkg::HeightReset, 1'b0);
        random_frames(20);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_escapes();
        test_min_size();
        test_max_size();
        test_clamped_regs();
        test_burst_odd_size();
        test_reset_size();
        drain();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/rle8sd_pkg.sv
hw/rtl/rle8sd_span_unit.sv
hw/rtl/rle8sd_out_buf.sv
hw/rtl/bmp_rle8_span_decoder_top.sv
sim/tb_bmp_rle8_span_decoder_top.sv
